>>> rtl/core/ipv4c_pkg.sv
package ipv4c_pkg;

  localparam int PORT_SLOTS = 16;
  localparam int SLOT_W     = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam logic [15:0] DF_MASK = 16'(1 << 14);

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_BIND   = 2'd1,
    CMD_UNBIND = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_DELIVER      = 4'd0,
    ST_ECHO         = 4'd1,
    ST_ICMP_OTHER   = 4'd2,
    ST_TOO_SHORT    = 4'd3,
    ST_BAD_CSUM     = 4'd4,
    ST_INVALID_DF   = 4'd5,
    ST_FRAG_UNSUP   = 4'd6,
    ST_UNKNOWN_PROT = 4'd7,
    ST_SHORT_XPORT  = 4'd8,
    ST_NO_LISTENER  = 4'd9,
    ST_PROT_MISM    = 4'd10,
    ST_BOUND        = 4'd11,
    ST_IN_USE       = 4'd12,
    ST_TABLE_FULL   = 4'd13,
    ST_UNBOUND      = 4'd14,
    ST_NOT_FOUND    = 4'd15
  } status_t;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;

  // lookup / update request to the port table
  typedef struct packed {
    logic        bind_en;
    logic        unbind_en;
    logic [15:0] key;
    logic [7:0]  proto;
  } tbl_req_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] hit_proto;
    logic       full;
  } tbl_rsp_t;

endpackage

>>> rtl/core/ipv4c_port_table.sv
module ipv4c_port_table (
  input  logic                clk,
  input  logic                rst_n,
  input  ipv4c_pkg::tbl_req_t req,
  output ipv4c_pkg::tbl_rsp_t rsp
);
  import ipv4c_pkg::*;

  logic [PORT_SLOTS-1:0] valid_r;
  logic [15:0]           port_r  [PORT_SLOTS];
  logic [7:0]            proto_r [PORT_SLOTS];

  logic [PORT_SLOTS-1:0] match;
  logic [SLOT_W-1:0]     hit_idx;
  logic [SLOT_W-1:0]     free_idx;
  logic                  hit;
  logic                  free_found;
  logic                  do_bind;
  logic                  do_unbind;

  always_comb begin
    for (int i = 0; i < PORT_SLOTS; i++) begin
      match[i] = valid_r[i] && (port_r[i] == req.key);
    end
  end

  // lowest matching slot and lowest free slot
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = PORT_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign rsp.hit       = hit;
  assign rsp.hit_proto = proto_r[hit_idx];
  assign rsp.full      = !free_found;

  assign do_bind   = req.bind_en && (req.key != 16'd0) && !hit && free_found;
  assign do_unbind = req.unbind_en && (req.key != 16'd0) && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_bind) begin
      valid_r[free_idx] <= 1'b1;
    end else if (do_unbind) begin
      valid_r[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_bind) begin
      port_r[free_idx]  <= req.key;
      proto_r[free_idx] <= req.proto;
    end
  end

endmodule

>>> rtl/core/ipv4_ingress_classifier_core.sv
// an accepted item is registered in the input register and its result in the result
// register; one item per cycle is accepted back to back while the receiver does not
// stall, set by the single-pass header update and the parallel port table compare;
// a result held by a stalled receiver holds the input register
// reset: synchronous active-low rst_n clears the packet state, marks every
// port slot free and sets max_packet_length to 1500
module ipv4_ingress_classifier_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // data_byte[7:0], port_value[23:8], bind_protocol[31:24]
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        in_tlast,   // last_byte
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // protocol[7:0], source_address[39:8],
                                  // source_port[55:40], destination_port[71:56],
                                  // packet_length[87:72]
  output logic [3:0]  out_tuser,  // status[3:0]
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // max_packet_length
);
  import ipv4c_pkg::*;

  // ---------------- configuration register ----------------
  logic [15:0] max_len_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 16'd1500;
    end else if (cfg_valid) begin
      max_len_r <= cfg_data;
    end
  end

  // ---------------- input register ----------------
  logic        s1_valid_r;
  cmd_t        s1_cmd_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [15:0] s1_port_r;
  logic [7:0]  s1_bproto_r;
  logic        advance;

  // the result register frees up when empty or taken this cycle
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r    <= cmd_t'(in_tuser);
      s1_byte_r   <= in_tdata[7:0];
      s1_last_r   <= in_tlast;
      s1_port_r   <= in_tdata[23:8];
      s1_bproto_r <= in_tdata[31:24];
    end
  end

  logic fire;
  assign fire = s1_valid_r && advance;

  // ---------------- per-packet state ----------------
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [16:0] header_sum_r, header_sum_nxt;
  logic [15:0] tot_len_r,    tot_len_nxt;
  logic        df_r,         df_nxt;
  logic [7:0]  proto_r,      proto_nxt;
  logic [31:0] src_r,        src_nxt;
  logic [7:0]  icmp_type_r,  icmp_type_nxt;
  logic [31:0] ports_r,      ports_nxt;

  logic [15:0] pos;
  logic [15:0] sum_add;
  logic [17:0] sum_raw;
  logic [16:0] sum_fold;
  logic        pkt;

  assign pkt     = fire && (s1_cmd_r == CMD_BYTE);
  assign pos     = byte_count_r;
  // even offsets are the high byte of a big-endian header word
  assign sum_add = pos[0] ? {8'd0, s1_byte_r} : {s1_byte_r, 8'd0};
  assign sum_raw = {1'b0, header_sum_r} + {2'd0, sum_add};
  assign sum_fold = {1'b0, sum_raw[15:0]} + {15'd0, sum_raw[17:16]};

  always_comb begin
    byte_count_nxt = (byte_count_r != 16'hFFFF) ? byte_count_r + 16'd1 : byte_count_r;
    header_sum_nxt = (pos < 16'd20) ? sum_fold : header_sum_r;
    tot_len_nxt    = tot_len_r;
    df_nxt         = df_r;
    proto_nxt      = proto_r;
    src_nxt        = src_r;
    icmp_type_nxt  = icmp_type_r;
    ports_nxt      = ports_r;
    if (pos == 16'd2) begin
      tot_len_nxt = {s1_byte_r, tot_len_r[7:0]};
    end else if (pos == 16'd3) begin
      tot_len_nxt = {tot_len_r[15:8], s1_byte_r};
    end else if (pos == 16'd6) begin
      df_nxt = |({s1_byte_r, 8'd0} & DF_MASK);
    end else if (pos == 16'd9) begin
      proto_nxt = s1_byte_r;
    end else if (pos >= 16'd12 && pos < 16'd16) begin
      src_nxt = {src_r[23:0], s1_byte_r};
    end else if (pos >= 16'd20 && pos < 16'd24) begin
      if (pos == 16'd20) begin
        icmp_type_nxt = s1_byte_r;
      end
      ports_nxt = {ports_r[23:0], s1_byte_r};
    end
  end

  // ---------------- port table ----------------
  tbl_req_t tbl_req;
  tbl_rsp_t tbl_rsp;

  always_comb begin
    tbl_req.bind_en   = fire && (s1_cmd_r == CMD_BIND);
    tbl_req.unbind_en = fire && (s1_cmd_r == CMD_UNBIND);
    tbl_req.key       = (s1_cmd_r == CMD_BYTE) ? ports_nxt[15:0] : s1_port_r;
    tbl_req.proto     = s1_bproto_r;
  end

  ipv4c_port_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  // ---------------- verdict ----------------
  status_t verdict;
  logic    with_ports;

  always_comb begin
    with_ports = 1'b0;
    verdict    = ST_DELIVER;
    if (byte_count_nxt < 16'd20) begin
      verdict = ST_TOO_SHORT;
    end else if (header_sum_nxt[15:0] != 16'hFFFF) begin
      verdict = ST_BAD_CSUM;
    end else if (tot_len_nxt > byte_count_nxt || tot_len_nxt > max_len_r) begin
      verdict = df_nxt ? ST_INVALID_DF : ST_FRAG_UNSUP;
    end else if (tot_len_nxt < 16'd20) begin
      verdict = ST_TOO_SHORT;
    end else if (proto_nxt == PROTO_ICMP) begin
      if (tot_len_nxt < 16'd28) begin
        verdict = ST_SHORT_XPORT;
      end else begin
        verdict = (icmp_type_nxt == ICMP_ECHO_REQ) ? ST_ECHO : ST_ICMP_OTHER;
      end
    end else if (proto_nxt == PROTO_UDP || proto_nxt == PROTO_TCP) begin
      if ((proto_nxt == PROTO_UDP && tot_len_nxt < 16'd28) ||
          (proto_nxt == PROTO_TCP && tot_len_nxt < 16'd40)) begin
        verdict = ST_SHORT_XPORT;
      end else begin
        with_ports = 1'b1;
        // a zero destination port never matches a binding
        if (ports_nxt[15:0] == 16'd0 || !tbl_rsp.hit) begin
          verdict = ST_NO_LISTENER;
        end else if (tbl_rsp.hit_proto != proto_nxt) begin
          verdict = ST_PROT_MISM;
        end else begin
          verdict = ST_DELIVER;
        end
      end
    end else begin
      verdict = ST_UNKNOWN_PROT;
    end
  end

  // packet state update; a verdict clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      header_sum_r <= '0;
      tot_len_r    <= '0;
      df_r         <= 1'b0;
      proto_r      <= '0;
      src_r        <= '0;
      icmp_type_r  <= '0;
      ports_r      <= '0;
    end else if (pkt) begin
      if (s1_last_r) begin
        byte_count_r <= '0;
        header_sum_r <= '0;
        tot_len_r    <= '0;
        df_r         <= 1'b0;
        proto_r      <= '0;
        src_r        <= '0;
        icmp_type_r  <= '0;
        ports_r      <= '0;
      end else begin
        byte_count_r <= byte_count_nxt;
        header_sum_r <= header_sum_nxt;
        tot_len_r    <= tot_len_nxt;
        df_r         <= df_nxt;
        proto_r      <= proto_nxt;
        src_r        <= src_nxt;
        icmp_type_r  <= icmp_type_nxt;
        ports_r      <= ports_nxt;
      end
    end
  end

  // ---------------- result register ----------------
  logic        res_en;
  status_t     res_status;
  logic [7:0]  res_proto;
  logic [31:0] res_src;
  logic [15:0] res_sport;
  logic [15:0] res_dport;
  logic [15:0] res_len;

  always_comb begin
    res_en     = 1'b0;
    res_status = ST_DELIVER;
    res_proto  = '0;
    res_src    = '0;
    res_sport  = '0;
    res_dport  = '0;
    res_len    = '0;
    case (s1_cmd_r)
      CMD_BYTE: begin
        res_en     = s1_last_r;
        res_status = verdict;
        res_proto  = proto_nxt;
        res_src    = src_nxt;
        res_sport  = with_ports ? ports_nxt[31:16] : 16'd0;
        res_dport  = with_ports ? ports_nxt[15:0] : 16'd0;
        res_len    = tot_len_nxt;
      end
      CMD_BIND: begin
        res_en    = 1'b1;
        res_proto = s1_bproto_r;
        res_dport = s1_port_r;
        if (s1_port_r == 16'd0) begin
          res_status = ST_NOT_FOUND;
        end else if (tbl_rsp.hit) begin
          res_status = ST_IN_USE;
        end else if (tbl_rsp.full) begin
          res_status = ST_TABLE_FULL;
        end else begin
          res_status = ST_BOUND;
        end
      end
      CMD_UNBIND: begin
        res_en     = 1'b1;
        res_dport  = s1_port_r;
        res_status = (s1_port_r != 16'd0 && tbl_rsp.hit) ? ST_UNBOUND : ST_NOT_FOUND;
      end
      default: begin
        res_en = 1'b0;
      end
    endcase
  end

  logic out_valid_r;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_en) begin
      out_tuser <= res_status;
      out_tdata <= {res_len, res_dport, res_sport, res_src, res_proto};
    end
  end

endmodule

>>> tb/ipv4_ingress_classifier_checker.sv
`timescale 1ns / 1ps
module ipv4_ingress_classifier_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import ipv4c_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [15:0] pkt_len;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [15:0] mtu;
  logic [15:0] nbytes;
  logic [16:0] csum;
  logic [15:0] tot_len;
  logic        df_bit;
  logic [7:0]  proto_cap;
  logic [31:0] src_cap;
  logic [7:0]  icmp_type;
  logic [31:0] ports_cap;
  logic        slot_used [PORT_SLOTS];
  logic [15:0] slot_port [PORT_SLOTS];
  logic [7:0]  slot_proto[PORT_SLOTS];

  function automatic int lookup_port(logic [15:0] p);
    for (int i = 0; i < PORT_SLOTS; i++)
      if (slot_used[i] && slot_port[i] == p) return i;
    return -1;
  endfunction

  function automatic status_t classify(output logic with_ports);
    int unsigned tl;
    int          idx;
    tl = tot_len;
    with_ports = 1'b0;
    if (nbytes < 20) return ST_TOO_SHORT;
    if (csum[15:0] != 16'hFFFF) return ST_BAD_CSUM;
    if (tl > nbytes || tl > mtu) return df_bit ? ST_INVALID_DF : ST_FRAG_UNSUP;
    if (tl < 20) return ST_TOO_SHORT;
    tl -= 20;
    if (proto_cap == PROTO_ICMP) begin
      if (tl < 8) return ST_SHORT_XPORT;
      return (icmp_type == ICMP_ECHO_REQ) ? ST_ECHO : ST_ICMP_OTHER;
    end else if (proto_cap == PROTO_UDP) begin
      if (tl < 8) return ST_SHORT_XPORT;
    end else if (proto_cap == PROTO_TCP) begin
      if (tl < 20) return ST_SHORT_XPORT;
    end else begin
      return ST_UNKNOWN_PROT;
    end
    with_ports = 1'b1;
    if (ports_cap[15:0] == 16'd0) return ST_NO_LISTENER;
    idx = lookup_port(ports_cap[15:0]);
    if (idx < 0) return ST_NO_LISTENER;
    if (slot_proto[idx] != proto_cap) return ST_PROT_MISM;
    return ST_DELIVER;
  endfunction

  task automatic clear_packet();
    nbytes = 0; csum = 0; tot_len = 0; df_bit = 0;
    proto_cap = 0; src_cap = 0; icmp_type = 0; ports_cap = 0;
  endtask

  // predict the verdict for one accepted item
  task automatic predict_item(cmd_t cmd, logic [7:0] b, logic last,
                              logic [15:0] port, logic [7:0] bproto);
    verdict_t    v;
    logic [16:0] s;
    logic        wp;
    int          idx;
    v = '0;
    case (cmd)
      CMD_BYTE: begin
        if (nbytes < 20) begin
          s = csum + (nbytes[0] ? {9'd0, b} : {1'b0, b, 8'd0});
          csum = {1'b0, s[15:0]} + s[16];
        end
        case (nbytes)
          16'd2: tot_len[15:8] = b;
          16'd3: tot_len[7:0] = b;
          16'd6: df_bit = b[6];
          16'd9: proto_cap = b;
          16'd12, 16'd13, 16'd14, 16'd15: src_cap = {src_cap[23:0], b};
          16'd20, 16'd21, 16'd22, 16'd23: begin
            if (nbytes == 20) icmp_type = b;
            ports_cap = {ports_cap[23:0], b};
          end
          default: ;
        endcase
        if (nbytes != 16'hFFFF) nbytes++;
        if (last) begin
          v.status = classify(wp);
          v.protocol = proto_cap;
          v.src_addr = src_cap;
          if (wp) begin
            v.l4_sport = ports_cap[31:16];
            v.l4_dport = ports_cap[15:0];
          end
          v.pkt_len = tot_len;
          clear_packet();
          verdict_q.push_back(v);
        end
      end
      CMD_BIND: begin
        v.protocol = bproto;
        v.l4_dport = port;
        if (port == 0) v.status = ST_NOT_FOUND;
        else if (lookup_port(port) >= 0) v.status = ST_IN_USE;
        else begin
          v.status = ST_TABLE_FULL;
          for (int i = 0; i < PORT_SLOTS; i++)
            if (!slot_used[i]) begin
              slot_used[i] = 1; slot_port[i] = port; slot_proto[i] = bproto;
              v.status = ST_BOUND;
              break;
            end
        end
        verdict_q.push_back(v);
      end
      CMD_UNBIND: begin
        v.l4_dport = port;
        idx = (port == 0) ? -1 : lookup_port(port);
        if (idx < 0) v.status = ST_NOT_FOUND;
        else begin
          slot_used[idx] = 0; slot_port[idx] = 0; slot_proto[idx] = 0;
          v.status = ST_UNBOUND;
        end
        verdict_q.push_back(v);
      end
      default: ;
    endcase
  endtask

  assign pending = verdict_q.size();

  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst_n) begin
      mtu <= 16'd1500;
      clear_packet();
      for (int i = 0; i < PORT_SLOTS; i++) begin
        slot_used[i] = 0; slot_port[i] = 0; slot_proto[i] = 0;
      end
      verdict_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) mtu <= cfg_data;
      if (in_tvalid && in_tready)
        predict_item(cmd_t'(in_tuser), in_tdata[7:0], in_tlast, in_tdata[23:8],
                     in_tdata[31:24]);
      if (out_tvalid && out_tready) begin
        got = {status_t'(out_tuser), out_tdata[7:0], out_tdata[39:8], out_tdata[55:40],
               out_tdata[71:56], out_tdata[87:72]};
        if (verdict_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/ipv4_ingress_classifier_core_test.sv
`timescale 1ns / 1ps
module ipv4_ingress_classifier_core_test;
  import ipv4c_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [87:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          stall_free = 0;

  always #5 clk = ~clk;

  ipv4_ingress_classifier_core dut (.*);
  ipv4_ingress_classifier_checker chk (.*);

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("ipv4_ingress_classifier_core_test: errors");
      $finish;
    end
  end

  // receiver stall, drawn per item, with stretches of no stall
  initial begin
    int w;
    forever begin
      @(negedge clk);
      w = stall_free ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send(cmd_t cmd, logic [7:0] b, logic last = 0,
                      logic [15:0] port = 0, logic [7:0] proto = 0);
    int w;
    w = stall_free ? 0 : $urandom_range(0, 9);
    if (w > 0) begin
      in_tvalid <= 0;
      repeat (w) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {proto, port, b};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_mtu(logic [15:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // build a header with a correct or corrupted checksum, then a transport part
  task automatic send_packet(logic [7:0] proto, logic [15:0] tlen, int nbytes,
                             logic df, logic [7:0] icmp_t, logic [15:0] sport,
                             logic [15:0] dport, bit bad_csum);
    logic [7:0]  hdr[20];
    logic [31:0] acc;
    logic [7:0]  b;
    acc = 0;
    for (int i = 0; i < 20; i++) hdr[i] = 8'($urandom);
    hdr[0] = 8'h45;
    hdr[2] = tlen[15:8]; hdr[3] = tlen[7:0];
    hdr[6] = {hdr[6][7], df, hdr[6][5:0]};
    hdr[9] = proto;
    hdr[10] = 0; hdr[11] = 0;
    for (int i = 0; i < 20; i += 2) acc += {hdr[i], hdr[i+1]};
    while (acc[31:16] != 0) acc = acc[15:0] + acc[31:16];
    acc = ~acc;
    hdr[10] = acc[15:8]; hdr[11] = acc[7:0];
    if (bad_csum) hdr[10] ^= 8'h01 << $urandom_range(0, 7);
    for (int i = 0; i < nbytes; i++) begin
      if (i < 20) b = hdr[i];
      else if (i == 20) b = (proto == PROTO_ICMP) ? icmp_t : sport[15:8];
      else if (i == 21) b = sport[7:0];
      else if (i == 22) b = dport[15:8];
      else if (i == 23) b = dport[7:0];
      else b = 8'($urandom);
      send(CMD_BYTE, b, i == nbytes - 1);
    end
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 5))
      0: return PROTO_ICMP;
      1, 2: return PROTO_UDP;
      3, 4: return PROTO_TCP;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    return ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 24)) : 16'($urandom);
  endfunction

  initial begin
    int items;
    int n, tl;
    logic [7:0] pr;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: table ops, each verdict, extremes
    send(CMD_BIND, 0, 0, 16'd0, 8'hFF);
    send(CMD_BIND, 0, 0, 16'd7, PROTO_UDP);
    send(CMD_BIND, 0, 0, 16'd7, PROTO_TCP);
    send(CMD_BIND, 0, 0, 16'hFFFF, PROTO_TCP);
    send(CMD_NONE, 8'hFF, 1, 16'hFFFF, 8'hFF);
    send_packet(PROTO_UDP, 28, 28, 0, 0, 16'h0000, 16'd7, 0);
    send_packet(PROTO_TCP, 40, 40, 1, 0, 16'hFFFF, 16'd7, 0);
    send_packet(PROTO_TCP, 44, 44, 0, 0, 16'h1234, 16'hFFFF, 0);
    send_packet(PROTO_UDP, 28, 28, 0, 0, 16'd5, 16'd0, 0);
    send_packet(PROTO_ICMP, 28, 28, 0, ICMP_ECHO_REQ, 0, 0, 0);
    send_packet(PROTO_ICMP, 30, 30, 0, 8'd0, 0, 0, 0);
    send_packet(PROTO_ICMP, 24, 24, 0, ICMP_ECHO_REQ, 0, 0, 0);
    send_packet(8'd99, 20, 20, 0, 0, 0, 0, 0);
    send_packet(PROTO_UDP, 28, 19, 0, 0, 0, 0, 0);
    send_packet(PROTO_UDP, 28, 28, 0, 0, 0, 7, 1);
    send_packet(PROTO_UDP, 60, 30, 1, 0, 0, 7, 0);
    send_packet(PROTO_UDP, 60, 30, 0, 0, 0, 7, 0);
    send_packet(PROTO_UDP, 10, 30, 0, 0, 0, 7, 0);
    send(CMD_UNBIND, 0, 0, 16'd7);
    send(CMD_UNBIND, 0, 0, 16'd7);
    send(CMD_UNBIND, 0, 0, 16'd0);
    for (int p = 1; p <= 17; p++) send(CMD_BIND, 0, 0, 16'(p), PROTO_UDP);
    quiesce();

    write_mtu(16'd68);
    send_packet(PROTO_UDP, 69, 69, 1, 0, 0, 3, 0);
    send_packet(PROTO_UDP, 68, 70, 0, 0, 0, 3, 0);
    quiesce();
    write_mtu(16'hFFFF);

    items = 0;
    for (int ph = 0; ph < 6; ph++) begin
      quiesce();
      case (ph)
        0: write_mtu(16'd1500);
        1: write_mtu(16'd68);
        2: write_mtu(16'hFFFF);
        3: write_mtu(16'd40);
        4: write_mtu(16'($urandom_range(68, 200)));
        default: write_mtu(16'd1500);
      endcase
      stall_free = (ph == 2);
      while (items < (ph + 1) * 190) begin
        case ($urandom_range(0, 9))
          0: begin send(CMD_BIND, 0, 0, pick_port(), pick_proto()); items++; end
          1: begin send(CMD_UNBIND, 0, 0, pick_port()); items++; end
          2: begin
            // noise: raw bytes, odd commands and stray last marks
            send(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)),
                 16'($urandom), 8'($urandom));
            items++;
          end
          default: begin
            pr = pick_proto();
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 60) : $urandom_range(20, 48);
            tl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 80) : n;
            send_packet(pr, 16'(tl), n, 1'($urandom_range(0, 1)),
                        $urandom_range(0, 1) ? 8'd8 : 8'($urandom),
                        pick_port(), pick_port(), $urandom_range(0, 9) == 0);
            items += n;
          end
        endcase
      end
    end
    stall_free = 0;

    quiesce();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ipv4_ingress_classifier_core_test: clean");
    else
      $display("ipv4_ingress_classifier_core_test: errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ipv4c_pkg.sv
rtl/core/ipv4c_port_table.sv
rtl/core/ipv4_ingress_classifier_core.sv
tb/ipv4_ingress_classifier_checker.sv
tb/ipv4_ingress_classifier_core_test.sv
